[rtl/core/sfp_pkg.sv]
// shared types and constants for the spherical flip projection
package sfp_pkg;

    localparam int CW    = 32;          // coordinate width
    localparam int DW    = CW + 1;      // offset width
    localparam int RADW  = 2 * DW;      // sum of squares width
    localparam int REMW  = DW + 2;      // square root remainder width
    localparam int NUMW  = 2 * DW + 1;  // dividend width with rounding half
    localparam int QW    = CW - 1;      // quotient bits below saturation
    localparam int RW    = CW - 1;      // radius width
    localparam int IDXW  = 2;

    localparam logic [IDXW-1:0] CFG_RADIUS = 2'd0;
    localparam logic [IDXW-1:0] CFG_VIEW_X = 2'd1;
    localparam logic [IDXW-1:0] CFG_VIEW_Y = 2'd2;
    localparam logic [IDXW-1:0] CFG_VIEW_Z = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] point_z;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] flipped_x;
        logic signed [CW-1:0] flipped_y;
        logic signed [CW-1:0] flipped_z;
        logic [CW-1:0]        distance;
        logic                 outside_sphere;
        logic                 at_viewpoint;
    } t_out;

    typedef struct packed {
        logic [2:0]          neg_d;
        logic [2:0][DW-1:0]  ad;
    } t_sq_carry;

    typedef struct packed {
        logic [2:0]    neg;
        logic [2:0]    sat;
        logic [CW-1:0] distance;
        logic          outside;
        logic          at_view;
    } t_dv_carry;

endpackage

[rtl/core/sfp_sqrt_cell.sv]
// one digit step of the square root chain
module sfp_sqrt_cell (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [sfp_pkg::REMW-1:0] i_rem,
    input  logic [sfp_pkg::DW-1:0]   i_root,
    input  logic [sfp_pkg::RADW-1:0] i_rad,
    output logic [sfp_pkg::REMW-1:0] o_rem,
    output logic [sfp_pkg::DW-1:0]   o_root,
    output logic [sfp_pkg::RADW-1:0] o_rad
);
    import sfp_pkg::*;

    logic [REMW+1:0] w_cur;
    logic [REMW+1:0] w_trial;
    logic [REMW+1:0] w_diff;
    logic            w_take;

    assign w_cur   = {i_rem, i_rad[RADW-1 -: 2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_take  = w_cur >= w_trial;
    assign w_diff  = w_cur - w_trial;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= w_take ? w_diff[REMW-1:0] : w_cur[REMW-1:0];
            o_root <= {i_root[DW-2:0], w_take};
            o_rad  <= {i_rad[RADW-3:0], 2'b00};
        end
    end
endmodule

[rtl/core/sfp_div_cell.sv]
// one quotient bit step of the divide chain
module sfp_div_cell (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [sfp_pkg::DW-1:0] i_den,
    input  logic [sfp_pkg::DW-1:0] i_rem,
    input  logic [sfp_pkg::QW-1:0] i_low,
    input  logic [sfp_pkg::QW-1:0] i_q,
    output logic [sfp_pkg::DW-1:0] o_den,
    output logic [sfp_pkg::DW-1:0] o_rem,
    output logic [sfp_pkg::QW-1:0] o_low,
    output logic [sfp_pkg::QW-1:0] o_q
);
    import sfp_pkg::*;

    logic [DW:0] w_cur;
    logic [DW:0] w_diff;
    logic        w_take;

    assign w_cur  = {i_rem, i_low[QW-1]};
    assign w_take = w_cur >= {1'b0, i_den};
    assign w_diff = w_cur - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_den <= i_den;
            o_rem <= w_take ? w_diff[DW-1:0] : w_cur[DW-1:0];
            o_low <= {i_low[QW-2:0], 1'b0};
            o_q   <= {i_q[QW-2:0], w_take};
        end
    end
endmodule

[rtl/core/spherical_flip_projection.sv]
// top level of the spherical flip projection pipeline
// spherical flip projection: one 3d point per request in, one result out
// input channel: i_in_valid / o_in_stall carry the point; a request is taken
// at a clock edge with valid high and stall low
// output channel: o_out_valid / i_out_stall carry the flipped offset, the
// distance to the viewpoint and the outside / at-viewpoint flags
// config: write radius or viewpoint through i_cfg_wr_en, index and data, only
// while no request is in flight
// throughput: one request per cycle while no result is stalled at the output,
// set by the pipelined chains of cells; pipeline from accept to the output
// register: offset, squares and sum stages, 33 square root cells (one root bit
// each), scale, product and rounding stages, 31 divide cells (one quotient bit
// each) and the output register
// reset: all stage valids clear, radius returns to 1.0, viewpoint to origin
// stall: when the output register holds a result that is stalled, the whole
// pipe freezes and o_in_stall is raised; nothing is lost or repeated
module spherical_flip_projection (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  sfp_pkg::t_in             i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output sfp_pkg::t_out            o_out,
    input  logic                     i_cfg_wr_en,
    input  logic [sfp_pkg::IDXW-1:0] i_cfg_idx,
    input  logic [sfp_pkg::CW-1:0]   i_cfg_data
);
    import sfp_pkg::*;

    // config registers
    logic [RW-1:0] r_radius;
    logic [CW-1:0] r_view_x, r_view_y, r_view_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RW'(1 << 16);
            r_view_x <= '0;
            r_view_y <= '0;
            r_view_z <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_RADIUS: r_radius <= i_cfg_data[RW-1:0];
                CFG_VIEW_X: r_view_x <= i_cfg_data;
                CFG_VIEW_Y: r_view_y <= i_cfg_data;
                CFG_VIEW_Z: r_view_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: the pipe moves unless a finished result is stalled
    logic w_en;
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    // stage 0: offset from viewpoint
    logic                r_v0;
    logic [2:0][DW-1:0]  r_d;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d[0] <= {i_in.point_x[CW-1], i_in.point_x} - {r_view_x[CW-1], r_view_x};
            r_d[1] <= {i_in.point_y[CW-1], i_in.point_y} - {r_view_y[CW-1], r_view_y};
            r_d[2] <= {i_in.point_z[CW-1], i_in.point_z} - {r_view_z[CW-1], r_view_z};
        end
    end

    // stage 1: magnitudes and squares
    logic                 r_v1;
    logic [2:0][RADW-1:0] r_sq;
    t_sq_carry            r_c1;
    logic [2:0][DW-1:0]   w_ad;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ad[i] = r_d[i][DW-1] ? DW'(-r_d[i]) : r_d[i];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i]       <= w_ad[i] * w_ad[i];
                r_c1.neg_d[i] <= r_d[i][DW-1];
                r_c1.ad[i]    <= w_ad[i];
            end
        end
    end

    // stage 2: sum of squares
    logic            r_v2;
    logic [RADW-1:0] r_s;
    t_sq_carry       r_c2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_c2 <= r_c1;
        end
    end

    // square root chain, one root bit per cell
    logic [REMW-1:0] w_srem  [DW+1];
    logic [DW-1:0]   w_sroot [DW+1];
    logic [RADW-1:0] w_srad  [DW+1];
    logic [DW-1:0]   r_vs;
    t_sq_carry       r_cs [DW];

    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;
    assign w_srad[0]  = r_s;

    for (genvar j = 0; j < DW; j++) begin : g_sqrt
        sfp_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_srem[j]),
            .i_root (w_sroot[j]),
            .i_rad  (w_srad[j]),
            .o_rem  (w_srem[j+1]),
            .o_root (w_sroot[j+1]),
            .o_rad  (w_srad[j+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cs[0] <= r_c2;
            for (int j = 1; j < DW; j++) begin
                r_cs[j] <= r_cs[j-1];
            end
        end
    end

    // stage 3: scale factor 2r - n, flags and saturated distance
    logic              r_v3;
    logic [DW-1:0]     r_n3;
    logic [DW-1:0]     r_ak;
    logic              r_kneg;
    t_sq_carry         r_c3;
    logic [CW-1:0]     r_dist3;
    logic              r_out3, r_at3;
    logic [DW:0]       w_k;
    logic [DW-1:0]     w_n;
    assign w_n = w_sroot[DW];
    assign w_k = {2'b00, r_radius, 1'b0} - {1'b0, w_n};
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n3    <= w_n;
            r_kneg  <= w_k[DW];
            r_ak    <= w_k[DW] ? DW'(-w_k) : w_k[DW-1:0];
            r_c3    <= r_cs[DW-1];
            r_dist3 <= w_n[DW-1] ? '1 : w_n[CW-1:0];
            r_out3  <= w_n >= {2'b00, r_radius};
            r_at3   <= w_n == '0;
        end
    end

    // stage 4: products |d| * |k|
    logic                 r_v4;
    logic [2:0][RADW-1:0] r_prod;
    logic [DW-1:0]        r_n4;
    t_dv_carry            r_c4;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i]   <= r_c3.ad[i] * r_ak;
                r_c4.neg[i] <= r_c3.neg_d[i] ^ r_kneg;
            end
            r_c4.sat      <= '0;
            r_c4.distance <= r_dist3;
            r_c4.outside  <= r_out3;
            r_c4.at_view  <= r_at3;
            r_n4          <= r_n3;
        end
    end

    // stage 5: add half divisor, detect quotient overflow, seed remainders
    logic                 r_v5;
    logic [2:0][DW-1:0]   r_rem5;
    logic [2:0][QW-1:0]   r_low5;
    logic [DW-1:0]        r_n5;
    t_dv_carry            r_c5;
    logic [2:0][NUMW-1:0] w_num;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_num[i] = {1'b0, r_prod[i]} + NUMW'(r_n4 >> 1);
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_rem5[i]   <= w_num[i][QW +: DW];
                r_low5[i]   <= w_num[i][QW-1:0];
                r_c5.sat[i] <= w_num[i][NUMW-1:QW] >= (NUMW-QW)'(r_n4);
            end
            r_c5.neg      <= r_c4.neg;
            r_c5.distance <= r_c4.distance;
            r_c5.outside  <= r_c4.outside;
            r_c5.at_view  <= r_c4.at_view;
            r_n5          <= r_n4;
        end
    end

    // divide chains, one quotient bit per cell, one lane per axis
    logic [DW-1:0] w_dden [3][QW+1];
    logic [DW-1:0] w_drem [3][QW+1];
    logic [QW-1:0] w_dlow [3][QW+1];
    logic [QW-1:0] w_dq   [3][QW+1];
    logic [QW-1:0] r_vd;
    t_dv_carry     r_cd [QW];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        assign w_dden[a][0] = r_n5;
        assign w_drem[a][0] = r_rem5[a];
        assign w_dlow[a][0] = r_low5[a];
        assign w_dq[a][0]   = '0;
        for (genvar j = 0; j < QW; j++) begin : g_div
            sfp_div_cell u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_den (w_dden[a][j]),
                .i_rem (w_drem[a][j]),
                .i_low (w_dlow[a][j]),
                .i_q   (w_dq[a][j]),
                .o_den (w_dden[a][j+1]),
                .o_rem (w_drem[a][j+1]),
                .o_low (w_dlow[a][j+1]),
                .o_q   (w_dq[a][j+1])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cd[0] <= r_c5;
            for (int j = 1; j < QW; j++) begin
                r_cd[j] <= r_cd[j-1];
            end
        end
    end

    // final sign, saturation and zero forcing
    logic [2:0][CW-1:0] w_f;
    t_dv_carry          w_cl;
    assign w_cl = r_cd[QW-1];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            priority if (w_cl.at_view) begin
                w_f[i] = '0;
            end else if (w_cl.sat[i]) begin
                w_f[i] = w_cl.neg[i] ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
            end else if (w_cl.neg[i]) begin
                w_f[i] = CW'(-{1'b0, w_dq[i][QW]});
            end else begin
                w_f[i] = {1'b0, w_dq[i][QW]};
            end
        end
    end

    t_out r_out;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.flipped_x      <= w_f[0];
            r_out.flipped_y      <= w_f[1];
            r_out.flipped_z      <= w_f[2];
            r_out.distance       <= w_cl.distance;
            r_out.outside_sphere <= w_cl.outside;
            r_out.at_viewpoint   <= w_cl.at_view;
        end
    end
    assign o_out = r_out;

    // stage valids
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vs <= '0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_vd <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_in_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_vs <= {r_vs[DW-2:0], r_v2};
            r_v3 <= r_vs[DW-1];
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_vd <= {r_vd[QW-2:0], r_v5};
            r_ov <= r_vd[QW-1];
        end
    end
    assign o_out_valid = r_ov;

    // a point at the viewpoint gives a zero vector and zero distance
    a_zero_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.at_viewpoint |->
            r_out.flipped_x == '0 && r_out.flipped_y == '0 && r_out.flipped_z == '0)
        else $error("flipped vector not zero at viewpoint");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.at_viewpoint |-> r_out.distance == '0)
        else $error("distance not zero at viewpoint");

    // an accepted request lands in the first stage
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_v0)
        else $error("accepted request lost at first stage");

    // a frozen pipe keeps the valids of its square root and divide chains
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vs) && $stable(r_vd))
        else $error("pipe moved while stalled");
endmodule

[bench/spherical_flip_projection_test.sv]
// testbench for the spherical flip projection: directed table, random points, scoreboard
module spherical_flip_projection_test;
    import sfp_pkg::*;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_in_valid = 1'b0;
    logic            o_in_stall;
    t_in             i_in = '0;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    t_out            o_out;
    logic            i_cfg_wr_en = 1'b0;
    logic [IDXW-1:0] i_cfg_idx = CFG_RADIUS;
    logic [CW-1:0]   i_cfg_data = '0;

    spherical_flip_projection dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [RW-1:0]        radius = RW'(32'h0001_0000);
    logic signed [CW-1:0] view_x = '0, view_y = '0, view_z = '0;

    t_out pending_flips[$];
    int   n_errors = 0;
    int   n_results = 0;
    int   n_sent = 0;
    int   n_outside = 0;
    int   n_at_view = 0;
    int   burst_left = 0;

    // flip one point about the sphere around the viewpoint
    function automatic t_out flip_point(t_in p);
        longint      d[3];
        longint      k;
        logic [127:0] mag[3], sum, root, trial, ak, num, q, n;
        logic [CW-1:0] f[3];
        bit          neg;
        t_out        r;
        d[0] = longint'(p.point_x) - longint'(view_x);
        d[1] = longint'(p.point_y) - longint'(view_y);
        d[2] = longint'(p.point_z) - longint'(view_z);
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = 128'(d[i] < 0 ? -d[i] : d[i]);
            sum = sum + mag[i] * mag[i];
        end
        // integer square root, one bit at a time
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (128'(1) << b);
            if (trial * trial <= sum)
                root = trial;
        end
        n = root;
        k = 2 * longint'({1'b0, radius}) - longint'(n[63:0]);
        ak = 128'(k < 0 ? -k : k);
        for (int i = 0; i < 3; i++) begin
            if (n == 0) begin
                f[i] = '0;
            end else begin
                // round to nearest, ties away from zero, then saturate
                num = mag[i] * ak + (n >> 1);
                q = num / n;
                neg = (d[i] < 0) != (k < 0);
                if (neg) begin
                    if (q > 128'h8000_0000) q = 128'h8000_0000;
                    f[i] = CW'(-q);
                end else begin
                    if (q > 128'h7fff_ffff) q = 128'h7fff_ffff;
                    f[i] = q[CW-1:0];
                end
            end
        end
        r.flipped_x = f[0];
        r.flipped_y = f[1];
        r.flipped_z = f[2];
        r.distance = (n > 128'hffff_ffff) ? '1 : n[CW-1:0];
        r.outside_sphere = (n >= 128'(radius));
        r.at_viewpoint = (n == 0);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [CW-1:0] got, logic [CW-1:0] want);
        $display("result %0d: %s got %h expected %h", n_results, field, got, want);
        n_errors++;
    endtask

    // output side: compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_flips.size() == 0) begin
                $display("result %0d arrived with nothing expected", n_results);
                n_errors++;
            end else begin
                want = pending_flips.pop_front();
                if (o_out.flipped_x !== want.flipped_x)
                    report_mismatch("flipped_x", o_out.flipped_x, want.flipped_x);
                if (o_out.flipped_y !== want.flipped_y)
                    report_mismatch("flipped_y", o_out.flipped_y, want.flipped_y);
                if (o_out.flipped_z !== want.flipped_z)
                    report_mismatch("flipped_z", o_out.flipped_z, want.flipped_z);
                if (o_out.distance !== want.distance)
                    report_mismatch("distance", o_out.distance, want.distance);
                if (o_out.outside_sphere !== want.outside_sphere)
                    report_mismatch("outside_sphere", CW'(o_out.outside_sphere),
                                    CW'(want.outside_sphere));
                if (o_out.at_viewpoint !== want.at_viewpoint)
                    report_mismatch("at_viewpoint", CW'(o_out.at_viewpoint),
                                    CW'(want.at_viewpoint));
                n_outside += want.outside_sphere;
                n_at_view += want.at_viewpoint;
            end
            n_results++;
        end
    end

    // receiver stall pattern: stall_clock picks a new random mode out of four
    int stall_mode = 0;
    int stall_clock = 0;
    always @(negedge i_clk) begin
        stall_clock++;
        if (stall_clock % 150 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_stall <= 1'b0;                                  // free flow
            1: i_out_stall <= ($urandom_range(0, 99) < 30);          // light random
            2: i_out_stall <= ((stall_clock % 23) < 15);             // long stalls
            default: i_out_stall <= ($urandom_range(0, 99) < 80);    // heavy random
        endcase
    end

    task automatic write_reg(logic [IDXW-1:0] idx, logic [CW-1:0] data);
        i_cfg_wr_en = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        case (idx)
            CFG_RADIUS: radius = data[RW-1:0];
            CFG_VIEW_X: view_x = data;
            CFG_VIEW_Y: view_y = data;
            CFG_VIEW_Z: view_z = data;
        endcase
    endtask

    // send one request; valid stays up inside a burst, drops for a gap between bursts
    task automatic send_point(t_in p, bit has_want, t_out want);
        t_out flip;
        if (burst_left == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        i_in_valid = 1'b1;
        i_in = p;
        do @(posedge i_clk); while (o_in_stall);
        flip = flip_point(p);
        if (has_want && flip !== want) begin
            $display("predictor disagrees with table row for point %h", p);
            n_errors++;
        end
        pending_flips.push_back(flip);
        n_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    // let the pipe empty before touching the registers
    task automatic drain();
        i_in_valid = 1'b0;
        burst_left = 0;
        while (pending_flips.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 | $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
            default: return $urandom;
        endcase
    endfunction

    typedef struct {
        t_in  pt;
        bit   has_want;
        t_out want;
    } t_row;

    t_row rows[$];

    task automatic run_random(int count, bit near_view);
        t_in p;
        for (int i = 0; i < count; i++) begin
            if (near_view && $urandom_range(0, 3) != 0) begin
                // offsets within +/-0x18000 of the viewpoint on each axis
                p.point_x = view_x + $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
                p.point_y = view_y + $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
                p.point_z = view_z + $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
                if ($urandom_range(0, 40) == 0) p = '{view_x, view_y, view_z};
            end else begin
                p = '{rand_coord(), rand_coord(), rand_coord()};
            end
            send_point(p, 1'b0, '0);
        end
    endtask

    initial begin
        // hand-checked rows at the reset setting: radius 1.0, viewpoint at origin
        rows.push_back('{'{32'sd0, 32'sd0, 32'sd0}, 1'b1, '{0, 0, 0, 0, 1'b0, 1'b1}});
        rows.push_back('{'{32'sh0001_0000, 32'sd0, 32'sd0}, 1'b1,
                         '{32'sh0001_0000, 0, 0, 32'h0001_0000, 1'b1, 1'b0}});
        rows.push_back('{'{32'sh0000_8000, 32'sd0, 32'sd0}, 1'b1,
                         '{32'sh0001_8000, 0, 0, 32'h0000_8000, 1'b0, 1'b0}});
        rows.push_back('{'{32'sd0, -32'sh0000_8000, 32'sd0}, 1'b1,
                         '{0, -32'sh0001_8000, 0, 32'h0000_8000, 1'b0, 1'b0}});
        rows.push_back('{'{32'sd0, 32'sd0, 32'sd1}, 1'b0, '0});
        // extremes and far points, against the predictor
        rows.push_back('{'{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff}, 1'b0, '0});
        rows.push_back('{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1'b0, '0});
        rows.push_back('{'{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0}, 1'b0, '0});
        rows.push_back('{'{32'sh8000_0000, 32'sd0, 32'sh7fff_ffff}, 1'b0, '0});
        rows.push_back('{'{-32'sd1, -32'sd1, -32'sd1}, 1'b0, '0});
        rows.push_back('{'{32'sh0000_4000, -32'sh0000_3000, 32'sh0000_2000}, 1'b0, '0});
        rows.push_back('{'{32'sh0001_0001, 32'sd0, 32'sd0}, 1'b0, '0});
        rows.push_back('{'{32'sh0000_ffff, 32'sd0, 32'sd0}, 1'b0, '0});
        rows.push_back('{'{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f}, 1'b0, '0});

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) send_point(rows[i].pt, rows[i].has_want, rows[i].want);
        run_random(250, 1'b1);
        drain();

        // largest radius, viewpoint at the positive corner
        write_reg(CFG_RADIUS, 32'h7fff_ffff);
        write_reg(CFG_VIEW_X, 32'h7fff_ffff);
        write_reg(CFG_VIEW_Y, 32'h7fff_ffff);
        write_reg(CFG_VIEW_Z, 32'h7fff_ffff);
        send_point('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1'b0, '0);
        run_random(250, 1'b0);
        drain();

        // zero radius: every point, the viewpoint itself too, lands outside
        write_reg(CFG_RADIUS, 32'h8000_0000);
        write_reg(CFG_VIEW_X, 32'h8000_0000);
        write_reg(CFG_VIEW_Y, 32'h8000_0000);
        write_reg(CFG_VIEW_Z, 32'h8000_0000);
        send_point('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1'b0, '0);
        run_random(150, 1'b1);
        drain();

        // smallest nonzero radius
        write_reg(CFG_RADIUS, 32'd1);
        write_reg(CFG_VIEW_X, 32'd0);
        run_random(150, 1'b1);
        drain();

        // random settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_RADIUS, (ph % 2) ? $urandom : $urandom_range(1, 32'h0010_0000));
            write_reg(CFG_VIEW_X, $urandom);
            write_reg(CFG_VIEW_Y, $urandom);
            write_reg(CFG_VIEW_Z, $urandom);
            run_random(180, ph % 2 == 0);
            drain();
        end

        $display("sent %0d points, checked %0d results (%0d outside, %0d at viewpoint)",
                 n_sent, n_results, n_outside, n_at_view);
        $display("settings covered: reset, max radius, zero radius, unit lsb radius, random");
        if (n_errors == 0 && pending_flips.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
rtl/core/sfp_pkg.sv
rtl/core/sfp_sqrt_cell.sv
rtl/core/sfp_div_cell.sv
rtl/core/spherical_flip_projection.sv
bench/spherical_flip_projection_test.sv
